[hw/rtl/dllce_pkg.sv]
package dllce_pkg;

    localparam int NODES     = 16;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = $clog2(NODES + 1);
    localparam int ADR_BITS  = $clog2(NODES);

    localparam logic [IDX_BITS-1:0] NONE_IDX = IDX_BITS'(NODES);

    typedef enum logic [4:0] {
        CMD_CLEAR      = 5'd0,
        CMD_INS_HEAD   = 5'd1,
        CMD_INS_TAIL   = 5'd2,
        CMD_CUR_HEAD   = 5'd3,
        CMD_CUR_TAIL   = 5'd4,
        CMD_RD_HEAD    = 5'd5,
        CMD_RD_TAIL    = 5'd6,
        CMD_DEL_HEAD   = 5'd7,
        CMD_DEL_TAIL   = 5'd8,
        CMD_DEL_AFTER  = 5'd9,
        CMD_DEL_BEFORE = 5'd10,
        CMD_INS_AFTER  = 5'd11,
        CMD_INS_BEFORE = 5'd12,
        CMD_RD_CUR     = 5'd13,
        CMD_WR_CUR     = 5'd14,
        CMD_NEXT       = 5'd15,
        CMD_PREV       = 5'd16
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOCURSOR = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RD1,
        S_RD2,
        S_WR1,
        S_WR2,
        S_WR3,
        S_OUT
    } state_t;

endpackage

[hw/rtl/doubly_linked_list_cursor_engine_core.sv]
// Sequence: after the command beat is accepted, the result beat is presented through the steps
// read, read, capture, write, write, output; clear instead sweeps the free chain, then outputs.
// Throughput: one command in flight; the input stalls until the result beat has left.
// Reset: asynchronous; the list is empty, then a pass rewrites the free
// chain 0,1,..,NODES-1 while the input stalls.
module doubly_linked_list_cursor_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  cmd,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] read_value,
    output logic [1:0]  status,
    output logic        cursor_valid,
    output logic [4:0]  element_count
);

    localparam int IB = dllce_pkg::IDX_BITS;
    localparam int AB = dllce_pkg::ADR_BITS;
    localparam int DB = dllce_pkg::DATA_BITS;

    // pool memories
    logic [DB-1:0] val_mem  [dllce_pkg::NODES];
    logic [IB-1:0] next_mem [dllce_pkg::NODES];
    logic [IB-1:0] prev_mem [dllce_pkg::NODES];

    dllce_pkg::state_t state_reg, state_next;

    logic [4:0]    cmd_reg;
    logic [DB-1:0] wval_reg;
    logic [IB-1:0] head_reg, tail_reg, cur_reg, free_reg, total_reg;
    logic [IB-1:0] a_reg, b_reg;        // link read results
    logic          clr_reg;             // free chain pass after reset
    logic [AB:0]   sweep_reg;
    logic [31:0]   rd_reg;
    logic [1:0]    st_reg;
    logic          ov_reg;

    // memory ports
    logic [AB-1:0] ra;
    logic [IB-1:0] rnext_q, rprev_q;
    logic [DB-1:0] rval_q;
    logic          nw_en, pw_en, vw_en;
    logic [AB-1:0] nw_a, pw_a, vw_a;
    logic [IB-1:0] nw_d, pw_d;

    always_ff @(posedge clk)
    begin
        rnext_q <= next_mem[ra];
        rprev_q <= prev_mem[ra];
        rval_q  <= val_mem[ra];
        if (nw_en)
        begin
            next_mem[nw_a] <= nw_d;
        end
        if (pw_en)
        begin
            prev_mem[pw_a] <= pw_d;
        end
        if (vw_en)
        begin
            val_mem[vw_a] <= wval_reg;
        end
    end

    logic fire_in, has_cur, empty;
    assign in_stall  = (state_reg != dllce_pkg::S_IDLE) || ov_reg;
    assign fire_in   = in_valid && !in_stall;
    assign has_cur   = cur_reg != dllce_pkg::NONE_IDX;
    assign empty     = head_reg == dllce_pkg::NONE_IDX;

    // read address: RD1 the first node, RD2 the node its link points at (delete after/before) or else the cursor node
    always_comb
    begin
        ra = free_reg[AB-1:0];
        case (state_reg)
            dllce_pkg::S_RD1:
            begin
                case (cmd_reg)
                    dllce_pkg::CMD_RD_HEAD, dllce_pkg::CMD_DEL_HEAD: ra = head_reg[AB-1:0];
                    dllce_pkg::CMD_RD_TAIL, dllce_pkg::CMD_DEL_TAIL: ra = tail_reg[AB-1:0];
                    dllce_pkg::CMD_RD_CUR, dllce_pkg::CMD_DEL_AFTER,
                    dllce_pkg::CMD_DEL_BEFORE, dllce_pkg::CMD_NEXT,
                    dllce_pkg::CMD_PREV: ra = cur_reg[AB-1:0];
                    default: ra = free_reg[AB-1:0];
                endcase
            end
            dllce_pkg::S_RD2:
            begin
                case (cmd_reg)
                    dllce_pkg::CMD_DEL_AFTER:  ra = rnext_q[AB-1:0];
                    dllce_pkg::CMD_DEL_BEFORE: ra = rprev_q[AB-1:0];
                    default: ra = cur_reg[AB-1:0];
                endcase
            end
            default: ra = free_reg[AB-1:0];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dllce_pkg::S_IDLE:
            begin
                if (fire_in)
                begin
                    state_next = (cmd == 5'(dllce_pkg::CMD_CLEAR)) ? dllce_pkg::S_CLEAR
                                                                    : dllce_pkg::S_RD1;
                end
            end
            dllce_pkg::S_CLEAR:
            begin
                if (sweep_reg == (AB+1)'(dllce_pkg::NODES - 1))
                    state_next = clr_reg ? dllce_pkg::S_IDLE : dllce_pkg::S_OUT;
            end
            dllce_pkg::S_RD1:   state_next = dllce_pkg::S_RD2;
            dllce_pkg::S_RD2:   state_next = dllce_pkg::S_WR1;
            dllce_pkg::S_WR1:   state_next = dllce_pkg::S_WR2;
            dllce_pkg::S_WR2:   state_next = dllce_pkg::S_WR3;
            dllce_pkg::S_WR3:   state_next = dllce_pkg::S_OUT;
            dllce_pkg::S_OUT:   state_next = dllce_pkg::S_IDLE;
            default:            state_next = dllce_pkg::S_IDLE;
        endcase
    end

    // data path: status in RD2, node writes and frees in WR2, neighbour links in WR3 (delete head: in WR2)
    logic [IB-1:0] head_n, tail_n, cur_n, free_n, total_n;
    logic [31:0]   rd_n;
    logic [1:0]    st_n;
    logic          give, take;
    logic [IB-1:0] give_idx;

    always_comb
    begin
        head_n = head_reg; tail_n = tail_reg; cur_n = cur_reg;
        free_n = free_reg; total_n = total_reg;
        rd_n = rd_reg; st_n = st_reg;
        nw_en = 1'b0; pw_en = 1'b0; vw_en = 1'b0;
        nw_a = '0; pw_a = '0; vw_a = '0; nw_d = '0; pw_d = '0;
        give = 1'b0; take = 1'b0; give_idx = '0;
        case (state_reg)
            dllce_pkg::S_IDLE:
            begin
                if (fire_in)
                begin
                    rd_n = '0;
                    st_n = dllce_pkg::ST_OK;
                    if (cmd == 5'(dllce_pkg::CMD_CLEAR))
                    begin
                        head_n  = dllce_pkg::NONE_IDX;
                        tail_n  = dllce_pkg::NONE_IDX;
                        cur_n   = dllce_pkg::NONE_IDX;
                        free_n  = '0;
                        total_n = '0;
                    end
                end
            end
            dllce_pkg::S_CLEAR:
            begin
                // rebuild the free chain one entry a cycle
                nw_en = 1'b1; nw_a = sweep_reg[AB-1:0];
                nw_d = IB'(sweep_reg) + IB'(1);
            end
            dllce_pkg::S_RD2:
            begin
                // first read is out: status and read data
                case (cmd_reg)
                    dllce_pkg::CMD_INS_HEAD, dllce_pkg::CMD_INS_TAIL:
                    begin
                        if (free_reg == dllce_pkg::NONE_IDX) st_n = dllce_pkg::ST_FULL;
                    end
                    dllce_pkg::CMD_INS_AFTER, dllce_pkg::CMD_INS_BEFORE:
                    begin
                        if (has_cur && free_reg == dllce_pkg::NONE_IDX)
                            st_n = dllce_pkg::ST_FULL;
                    end
                    dllce_pkg::CMD_RD_HEAD, dllce_pkg::CMD_RD_TAIL:
                    begin
                        if (empty) st_n = dllce_pkg::ST_EMPTY;
                        else rd_n = 32'(signed'(rval_q));
                    end
                    dllce_pkg::CMD_RD_CUR:
                    begin
                        if (!has_cur) st_n = dllce_pkg::ST_NOCURSOR;
                        else rd_n = 32'(signed'(rval_q));
                    end
                    default: ;
                endcase
            end
            dllce_pkg::S_WR2:
            begin
                // new node, freed node, cursor moves
                case (cmd_reg)
                    dllce_pkg::CMD_INS_HEAD:
                    begin
                        if (st_reg == dllce_pkg::ST_OK)
                        begin
                            vw_en = 1'b1; vw_a = free_reg[AB-1:0];
                            nw_en = 1'b1; nw_a = free_reg[AB-1:0]; nw_d = head_reg;
                            pw_en = 1'b1; pw_a = free_reg[AB-1:0];
                            pw_d = dllce_pkg::NONE_IDX;
                        end
                    end
                    dllce_pkg::CMD_INS_TAIL:
                    begin
                        if (st_reg == dllce_pkg::ST_OK)
                        begin
                            vw_en = 1'b1; vw_a = free_reg[AB-1:0];
                            nw_en = 1'b1; nw_a = free_reg[AB-1:0];
                            nw_d = dllce_pkg::NONE_IDX;
                            pw_en = 1'b1; pw_a = free_reg[AB-1:0]; pw_d = tail_reg;
                        end
                    end
                    dllce_pkg::CMD_CUR_HEAD: cur_n = head_reg;
                    dllce_pkg::CMD_CUR_TAIL: cur_n = tail_reg;
                    dllce_pkg::CMD_DEL_HEAD:
                    begin
                        if (!empty)
                        begin
                            give = 1'b1; give_idx = head_reg;
                            if (head_reg == tail_reg)
                            begin
                                head_n = dllce_pkg::NONE_IDX;
                                tail_n = dllce_pkg::NONE_IDX;
                                cur_n  = dllce_pkg::NONE_IDX;
                            end
                            else
                            begin
                                if (cur_reg == head_reg) cur_n = dllce_pkg::NONE_IDX;
                                head_n = a_reg;
                                pw_en = 1'b1; pw_a = a_reg[AB-1:0];
                                pw_d = dllce_pkg::NONE_IDX;
                            end
                        end
                    end
                    dllce_pkg::CMD_DEL_TAIL:
                    begin
                        if (!empty)
                        begin
                            give = 1'b1; give_idx = tail_reg;
                            if (head_reg == tail_reg)
                            begin
                                head_n = dllce_pkg::NONE_IDX;
                                tail_n = dllce_pkg::NONE_IDX;
                                cur_n  = dllce_pkg::NONE_IDX;
                            end
                        end
                    end
                    dllce_pkg::CMD_DEL_AFTER:
                    begin
                        if (has_cur && cur_reg != tail_reg)
                        begin
                            give = 1'b1; give_idx = a_reg;
                        end
                    end
                    dllce_pkg::CMD_DEL_BEFORE:
                    begin
                        if (has_cur && cur_reg != head_reg)
                        begin
                            give = 1'b1; give_idx = a_reg;
                        end
                    end
                    dllce_pkg::CMD_INS_AFTER:
                    begin
                        if (has_cur && st_reg == dllce_pkg::ST_OK)
                        begin
                            vw_en = 1'b1; vw_a = free_reg[AB-1:0];
                            nw_en = 1'b1; nw_a = free_reg[AB-1:0]; nw_d = b_reg;
                            pw_en = 1'b1; pw_a = free_reg[AB-1:0]; pw_d = cur_reg;
                        end
                    end
                    dllce_pkg::CMD_INS_BEFORE:
                    begin
                        if (has_cur && st_reg == dllce_pkg::ST_OK)
                        begin
                            vw_en = 1'b1; vw_a = free_reg[AB-1:0];
                            nw_en = 1'b1; nw_a = free_reg[AB-1:0]; nw_d = cur_reg;
                            pw_en = 1'b1; pw_a = free_reg[AB-1:0]; pw_d = b_reg;
                        end
                    end
                    dllce_pkg::CMD_WR_CUR:
                    begin
                        if (has_cur)
                        begin
                            vw_en = 1'b1; vw_a = cur_reg[AB-1:0];
                        end
                    end
                    dllce_pkg::CMD_NEXT:
                    begin
                        if (has_cur)
                            cur_n = (cur_reg == tail_reg) ? dllce_pkg::NONE_IDX : a_reg;
                    end
                    dllce_pkg::CMD_PREV:
                    begin
                        if (has_cur)
                            cur_n = (cur_reg == head_reg) ? dllce_pkg::NONE_IDX : a_reg;
                    end
                    default: ;
                endcase
            end
            dllce_pkg::S_WR3:
            begin
                // neighbour links and end pointers
                case (cmd_reg)
                    dllce_pkg::CMD_INS_HEAD:
                    begin
                        if (st_reg == dllce_pkg::ST_OK)
                        begin
                            take = 1'b1;
                            if (head_reg == dllce_pkg::NONE_IDX) tail_n = free_reg;
                            else
                            begin
                                pw_en = 1'b1; pw_a = head_reg[AB-1:0]; pw_d = free_reg;
                            end
                            head_n = free_reg;
                        end
                    end
                    dllce_pkg::CMD_INS_TAIL:
                    begin
                        if (st_reg == dllce_pkg::ST_OK)
                        begin
                            take = 1'b1;
                            if (tail_reg == dllce_pkg::NONE_IDX) head_n = free_reg;
                            else
                            begin
                                nw_en = 1'b1; nw_a = tail_reg[AB-1:0]; nw_d = free_reg;
                            end
                            tail_n = free_reg;
                        end
                    end
                    dllce_pkg::CMD_DEL_TAIL:
                    begin
                        // single element was emptied in WR2
                        if (!empty && head_reg != tail_reg)
                        begin
                            if (cur_reg == tail_reg) cur_n = dllce_pkg::NONE_IDX;
                            tail_n = a_reg;
                            nw_en = 1'b1; nw_a = a_reg[AB-1:0];
                            nw_d = dllce_pkg::NONE_IDX;
                        end
                    end
                    dllce_pkg::CMD_DEL_AFTER:
                    begin
                        if (has_cur && cur_reg != tail_reg)
                        begin
                            nw_en = 1'b1; nw_a = cur_reg[AB-1:0]; nw_d = b_reg;
                            if (b_reg == dllce_pkg::NONE_IDX) tail_n = cur_reg;
                            else
                            begin
                                pw_en = 1'b1; pw_a = b_reg[AB-1:0]; pw_d = cur_reg;
                            end
                        end
                    end
                    dllce_pkg::CMD_DEL_BEFORE:
                    begin
                        if (has_cur && cur_reg != head_reg)
                        begin
                            pw_en = 1'b1; pw_a = cur_reg[AB-1:0]; pw_d = b_reg;
                            if (b_reg == dllce_pkg::NONE_IDX) head_n = cur_reg;
                            else
                            begin
                                nw_en = 1'b1; nw_a = b_reg[AB-1:0]; nw_d = cur_reg;
                            end
                        end
                    end
                    dllce_pkg::CMD_INS_AFTER:
                    begin
                        if (has_cur && st_reg == dllce_pkg::ST_OK)
                        begin
                            take = 1'b1;
                            if (b_reg == dllce_pkg::NONE_IDX) tail_n = free_reg;
                            else
                            begin
                                pw_en = 1'b1; pw_a = b_reg[AB-1:0]; pw_d = free_reg;
                            end
                            nw_en = 1'b1; nw_a = cur_reg[AB-1:0]; nw_d = free_reg;
                        end
                    end
                    dllce_pkg::CMD_INS_BEFORE:
                    begin
                        if (has_cur && st_reg == dllce_pkg::ST_OK)
                        begin
                            take = 1'b1;
                            if (b_reg == dllce_pkg::NONE_IDX) head_n = free_reg;
                            else
                            begin
                                nw_en = 1'b1; nw_a = b_reg[AB-1:0]; nw_d = free_reg;
                            end
                            pw_en = 1'b1; pw_a = cur_reg[AB-1:0]; pw_d = free_reg;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        // free chain push; only in WR2, where no other next write happens
        if (give)
        begin
            nw_en = 1'b1; nw_a = give_idx[AB-1:0]; nw_d = free_reg;
            free_n = give_idx;
            if (total_reg != '0) total_n = total_reg - IB'(1);
        end
        // free chain pop; a_reg holds the link of the taken node
        if (take)
        begin
            free_n  = a_reg;
            total_n = total_reg + IB'(1);
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dllce_pkg::S_CLEAR;
            head_reg  <= dllce_pkg::NONE_IDX;
            tail_reg  <= dllce_pkg::NONE_IDX;
            cur_reg   <= dllce_pkg::NONE_IDX;
            free_reg  <= '0;
            total_reg <= '0;
            clr_reg   <= 1'b1;
            sweep_reg <= '0;
            ov_reg    <= 1'b0;
            st_reg    <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_n; tail_reg <= tail_n; cur_reg <= cur_n;
            free_reg <= free_n; total_reg <= total_n;
            rd_reg <= rd_n; st_reg <= st_n;
            // sweep counter for the free chain pass
            if (fire_in)
                sweep_reg <= '0;
            else if (state_reg == dllce_pkg::S_CLEAR &&
                     sweep_reg != (AB+1)'(dllce_pkg::NODES - 1))
                sweep_reg <= sweep_reg + (AB+1)'(1);
            if (state_reg == dllce_pkg::S_CLEAR &&
                sweep_reg == (AB+1)'(dllce_pkg::NODES - 1))
                clr_reg <= 1'b0;
            // result beat held until taken
            if (state_reg == dllce_pkg::S_OUT)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    // command capture and link capture: RD1 read in a, RD2 read in b
    always_ff @(posedge clk)
    begin
        if (fire_in)
        begin
            cmd_reg  <= cmd;
            wval_reg <= DB'(value);
        end
        if (state_reg == dllce_pkg::S_RD2)
        begin
            case (cmd_reg)
                dllce_pkg::CMD_DEL_TAIL, dllce_pkg::CMD_PREV,
                dllce_pkg::CMD_DEL_BEFORE: a_reg <= rprev_q;
                default: a_reg <= rnext_q;
            endcase
        end
        if (state_reg == dllce_pkg::S_WR1)
        begin
            case (cmd_reg)
                dllce_pkg::CMD_DEL_BEFORE, dllce_pkg::CMD_INS_BEFORE: b_reg <= rprev_q;
                default: b_reg <= rnext_q;
            endcase
        end
    end

    assign out_valid     = ov_reg;
    assign read_value    = signed'(rd_reg);
    assign status        = st_reg;
    assign cursor_valid  = cur_reg != dllce_pkg::NONE_IDX;
    assign element_count = 5'(total_reg);

endmodule

[tb/doubly_linked_list_cursor_engine_core_tb.sv]
module doubly_linked_list_cursor_engine_core_tb;

    localparam int NODES = dllce_pkg::NODES;
    localparam int IB    = dllce_pkg::IDX_BITS;

    typedef struct {
        logic [4:0]         cmd;
        logic signed [31:0] value;
    } command_t;

    typedef struct {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic               cursor_valid;
        logic [4:0]         element_count;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [4:0]         cmd;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               cursor_valid;
    logic [4:0]         element_count;

    doubly_linked_list_cursor_engine_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .cursor_valid  (cursor_valid),
        .element_count (element_count)
    );

    // shadow copy of the list
    logic [31:0]   lst_val  [NODES];
    logic [IB-1:0] lst_next [NODES];
    logic [IB-1:0] lst_prev [NODES];
    logic [IB-1:0] lst_head, lst_tail, lst_cur, lst_free;
    int            lst_count;

    command_t pending_cmds [$];
    answer_t  expected_answers [$];
    int       mismatches;
    int       answers_seen;
    int       sent_count;
    int       queued_count;
    bit       stim_done;
    bit       hold_off;
    int       in_gap, out_gap;
    int       op_hits [32];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void list_reset();
        lst_head  = dllce_pkg::NONE_IDX;
        lst_tail  = dllce_pkg::NONE_IDX;
        lst_cur   = dllce_pkg::NONE_IDX;
        lst_free  = '0;
        lst_count = 0;
        for (int i = 0; i < NODES; i++)
        begin
            lst_next[i] = IB'(i + 1);
        end
    endfunction

    function automatic logic [IB-1:0] grab_node();
        logic [IB-1:0] n;
        n = lst_free;
        if (n != dllce_pkg::NONE_IDX)
        begin
            lst_free  = lst_next[n];
            lst_count = lst_count + 1;
        end
        return n;
    endfunction

    function automatic void drop_node(logic [IB-1:0] n);
        lst_next[n] = lst_free;
        lst_free    = n;
        if (lst_count > 0)
            lst_count = lst_count - 1;
    endfunction

    // apply one command to the shadow list and give the answer it should produce
    function automatic answer_t list_apply(command_t c);
        answer_t       a;
        logic [IB-1:0] n, d, x, cu;
        a.read_value = '0;
        a.status     = dllce_pkg::ST_OK;
        case (c.cmd)
            dllce_pkg::CMD_CLEAR: list_reset();
            dllce_pkg::CMD_INS_HEAD:
            begin
                n = grab_node();
                if (n == dllce_pkg::NONE_IDX)
                    a.status = dllce_pkg::ST_FULL;
                else
                begin
                    lst_val[n]  = c.value;
                    lst_prev[n] = dllce_pkg::NONE_IDX;
                    lst_next[n] = lst_head;
                    if (lst_head == dllce_pkg::NONE_IDX) lst_tail = n;
                    else lst_prev[lst_head] = n;
                    lst_head = n;
                end
            end
            dllce_pkg::CMD_INS_TAIL:
            begin
                n = grab_node();
                if (n == dllce_pkg::NONE_IDX)
                    a.status = dllce_pkg::ST_FULL;
                else
                begin
                    lst_val[n]  = c.value;
                    lst_next[n] = dllce_pkg::NONE_IDX;
                    lst_prev[n] = lst_tail;
                    if (lst_tail == dllce_pkg::NONE_IDX) lst_head = n;
                    else lst_next[lst_tail] = n;
                    lst_tail = n;
                end
            end
            dllce_pkg::CMD_CUR_HEAD: lst_cur = lst_head;
            dllce_pkg::CMD_CUR_TAIL: lst_cur = lst_tail;
            dllce_pkg::CMD_RD_HEAD, dllce_pkg::CMD_RD_TAIL:
            begin
                if (lst_head == dllce_pkg::NONE_IDX)
                    a.status = dllce_pkg::ST_EMPTY;
                else
                    a.read_value = lst_val[(c.cmd == dllce_pkg::CMD_RD_HEAD) ? lst_head
                                                                            : lst_tail];
            end
            dllce_pkg::CMD_DEL_HEAD:
            begin
                if (lst_head != dllce_pkg::NONE_IDX)
                begin
                    if (lst_head == lst_tail)
                    begin
                        drop_node(lst_head);
                        lst_head = dllce_pkg::NONE_IDX;
                        lst_tail = dllce_pkg::NONE_IDX;
                        lst_cur  = dllce_pkg::NONE_IDX;
                    end
                    else
                    begin
                        if (lst_cur == lst_head) lst_cur = dllce_pkg::NONE_IDX;
                        d = lst_head;
                        lst_head = lst_next[d];
                        lst_prev[lst_head] = dllce_pkg::NONE_IDX;
                        drop_node(d);
                    end
                end
            end
            dllce_pkg::CMD_DEL_TAIL:
            begin
                if (lst_head != dllce_pkg::NONE_IDX)
                begin
                    if (lst_head == lst_tail)
                    begin
                        drop_node(lst_tail);
                        lst_head = dllce_pkg::NONE_IDX;
                        lst_tail = dllce_pkg::NONE_IDX;
                        lst_cur  = dllce_pkg::NONE_IDX;
                    end
                    else
                    begin
                        if (lst_cur == lst_tail) lst_cur = dllce_pkg::NONE_IDX;
                        d = lst_tail;
                        lst_tail = lst_prev[d];
                        lst_next[lst_tail] = dllce_pkg::NONE_IDX;
                        drop_node(d);
                    end
                end
            end
            dllce_pkg::CMD_DEL_AFTER:
            begin
                cu = lst_cur;
                if (cu != dllce_pkg::NONE_IDX && cu != lst_tail)
                begin
                    d = lst_next[cu];
                    x = lst_next[d];
                    lst_next[cu] = x;
                    if (x == dllce_pkg::NONE_IDX) lst_tail = cu;
                    else lst_prev[x] = cu;
                    drop_node(d);
                end
            end
            dllce_pkg::CMD_DEL_BEFORE:
            begin
                cu = lst_cur;
                if (cu != dllce_pkg::NONE_IDX && cu != lst_head)
                begin
                    d = lst_prev[cu];
                    x = lst_prev[d];
                    lst_prev[cu] = x;
                    if (x == dllce_pkg::NONE_IDX) lst_head = cu;
                    else lst_next[x] = cu;
                    drop_node(d);
                end
            end
            dllce_pkg::CMD_INS_AFTER:
            begin
                cu = lst_cur;
                if (cu != dllce_pkg::NONE_IDX)
                begin
                    n = grab_node();
                    if (n == dllce_pkg::NONE_IDX)
                        a.status = dllce_pkg::ST_FULL;
                    else
                    begin
                        lst_val[n]  = c.value;
                        x = lst_next[cu];
                        lst_prev[n] = cu;
                        lst_next[n] = x;
                        if (x == dllce_pkg::NONE_IDX) lst_tail = n;
                        else lst_prev[x] = n;
                        lst_next[cu] = n;
                    end
                end
            end
            dllce_pkg::CMD_INS_BEFORE:
            begin
                cu = lst_cur;
                if (cu != dllce_pkg::NONE_IDX)
                begin
                    n = grab_node();
                    if (n == dllce_pkg::NONE_IDX)
                        a.status = dllce_pkg::ST_FULL;
                    else
                    begin
                        lst_val[n]  = c.value;
                        x = lst_prev[cu];
                        lst_next[n] = cu;
                        lst_prev[n] = x;
                        if (x == dllce_pkg::NONE_IDX) lst_head = n;
                        else lst_next[x] = n;
                        lst_prev[cu] = n;
                    end
                end
            end
            dllce_pkg::CMD_RD_CUR:
            begin
                if (lst_cur == dllce_pkg::NONE_IDX) a.status = dllce_pkg::ST_NOCURSOR;
                else a.read_value = lst_val[lst_cur];
            end
            dllce_pkg::CMD_WR_CUR:
            begin
                if (lst_cur != dllce_pkg::NONE_IDX) lst_val[lst_cur] = c.value;
            end
            dllce_pkg::CMD_NEXT:
            begin
                if (lst_cur != dllce_pkg::NONE_IDX)
                    lst_cur = (lst_cur == lst_tail) ? dllce_pkg::NONE_IDX : lst_next[lst_cur];
            end
            dllce_pkg::CMD_PREV:
            begin
                if (lst_cur != dllce_pkg::NONE_IDX)
                    lst_cur = (lst_cur == lst_head) ? dllce_pkg::NONE_IDX : lst_prev[lst_cur];
            end
            default: ;
        endcase
        a.cursor_valid  = (lst_cur != dllce_pkg::NONE_IDX);
        a.element_count = 5'(lst_count);
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(logic [4:0] c, logic signed [31:0] v);
        command_t item;
        item.cmd   = c;
        item.value = v;
        pending_cmds.push_back(item);
        queued_count++;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch at answer %0d: %s got %0h expected %0h",
                 answers_seen, what, got, want);
    endtask

    // command driver: predicts at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= '0;
            value    <= '0;
            in_gap   <= 0;
        end
        else
        begin
            logic     fire;
            command_t item;
            fire = in_valid && !in_stall;
            if (fire)
            begin
                item.cmd   = cmd;
                item.value = value;
                expected_answers.push_back(list_apply(item));
                op_hits[cmd]++;
                sent_count++;
            end
            if (in_valid && !fire)
                ;
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_cmds.size() > 0 && !hold_off)
            begin
                item = pending_cmds.pop_front();
                in_valid <= 1'b1;
                cmd      <= item.cmd;
                value    <= item.value;
                in_gap   <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // answer monitor and random receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            answer_t want;
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    $display("unexpected answer beat");
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (read_value !== want.read_value)
                        report("read_value", read_value, want.read_value);
                    if (status !== want.status)
                        report("status", 32'(status), 32'(want.status));
                    if (cursor_valid !== want.cursor_valid)
                        report("cursor_valid", 32'(cursor_valid), 32'(want.cursor_valid));
                    if (element_count !== want.element_count)
                        report("element_count", 32'(element_count),
                               32'(want.element_count));
                end
                answers_seen++;
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!stim_done && $urandom_range(0, 3) == 0)
                    out_gap <= pick_gap();
            end
        end
    end

    // stimulus
    initial
    begin
        int waited;
        int ops;
        int r;
        rst_n      = 1'b0;
        hold_off   = 1'b0;
        stim_done  = 1'b0;
        list_reset();
        for (int i = 0; i < NODES; i++)
        begin
            lst_val[i]  = '0;
            lst_prev[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-list cases, extremes, fill past full, cursor at ends
        queue_cmd(dllce_pkg::CMD_RD_HEAD, 0);
        queue_cmd(dllce_pkg::CMD_RD_CUR, 0);
        queue_cmd(dllce_pkg::CMD_DEL_TAIL, 0);
        queue_cmd(dllce_pkg::CMD_CUR_HEAD, 0);
        queue_cmd(dllce_pkg::CMD_NEXT, 0);
        queue_cmd(dllce_pkg::CMD_INS_AFTER, 5);
        queue_cmd(dllce_pkg::CMD_INS_HEAD, 32'sh7fffffff);
        queue_cmd(dllce_pkg::CMD_DEL_HEAD, 0);
        queue_cmd(dllce_pkg::CMD_INS_TAIL, 32'sh80000000);
        queue_cmd(dllce_pkg::CMD_CUR_TAIL, 0);
        queue_cmd(dllce_pkg::CMD_DEL_TAIL, 0);
        queue_cmd(dllce_pkg::CMD_INS_TAIL, -1);
        queue_cmd(dllce_pkg::CMD_CUR_HEAD, 0);
        queue_cmd(dllce_pkg::CMD_INS_BEFORE, 32'sh55555555);
        queue_cmd(dllce_pkg::CMD_INS_AFTER, 32'shaaaaaaaa);
        queue_cmd(dllce_pkg::CMD_DEL_BEFORE, 0);
        queue_cmd(dllce_pkg::CMD_DEL_AFTER, 0);
        queue_cmd(dllce_pkg::CMD_WR_CUR, 32'sh12345678);
        queue_cmd(dllce_pkg::CMD_RD_CUR, 0);
        queue_cmd(dllce_pkg::CMD_PREV, 0);
        for (int i = 0; i < 16; i++)
            queue_cmd(dllce_pkg::CMD_INS_TAIL, $urandom);
        queue_cmd(dllce_pkg::CMD_RD_TAIL, 0);
        queue_cmd(5'd31, 0);
        queue_cmd(dllce_pkg::CMD_CLEAR, 0);

        // random phases: insert share biased by phase so full and empty both recur
        for (int ph = 0; ph < 40; ph++)
        begin
            while (pending_cmds.size() > 4)
                @(posedge clk);
            ops = $urandom_range(30, 45);
            for (int k = 0; k < ops; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 1)
                    queue_cmd(dllce_pkg::CMD_CLEAR, 0);
                else if (r < 3)
                    queue_cmd(5'($urandom_range(17, 31)), $urandom);
                else if (r < 30 - (ph % 4) * 6)
                    queue_cmd(5'($urandom_range(1, 2)), pick_value());
                else if (r < 38)
                    queue_cmd(5'($urandom_range(11, 12)), pick_value());
                else
                    queue_cmd(5'($urandom_range(3, 16)), pick_value());
            end
            // pause the sender until all answers are in
            if (ph == 10 || ph == 25)
            begin
                while (sent_count < queued_count)
                    @(posedge clk);
                hold_off = 1'b1;
                while (expected_answers.size() > 0)
                    @(posedge clk);
                repeat (10) @(posedge clk);
                hold_off = 1'b0;
            end
        end

        while (sent_count < queued_count)
            @(posedge clk);
        stim_done = 1'b1;
        waited = 0;
        while (expected_answers.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display("%0d commands sent, %0d answers checked, pool-full answers and all", sent_count,
                 answers_seen);
        $display("op counts: clear %0d ins %0d del %0d cursor moves %0d",
                 op_hits[dllce_pkg::CMD_CLEAR],
                 op_hits[dllce_pkg::CMD_INS_HEAD] + op_hits[dllce_pkg::CMD_INS_TAIL] +
                 op_hits[dllce_pkg::CMD_INS_AFTER] + op_hits[dllce_pkg::CMD_INS_BEFORE],
                 op_hits[dllce_pkg::CMD_DEL_HEAD] + op_hits[dllce_pkg::CMD_DEL_TAIL] +
                 op_hits[dllce_pkg::CMD_DEL_AFTER] + op_hits[dllce_pkg::CMD_DEL_BEFORE],
                 op_hits[dllce_pkg::CMD_NEXT] + op_hits[dllce_pkg::CMD_PREV]);
        if (mismatches == 0 && expected_answers.size() == 0 && sent_count == queued_count)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #10000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
